// File: sv/melt_fraction_from_curves_defines.svh
// assertion macros for the melt fraction block
// used by mff_dp; no other dependencies
`ifndef MELT_FRACTION_FROM_CURVES_DEFINES_SVH
`define MELT_FRACTION_FROM_CURVES_DEFINES_SVH
`ifndef SYNTHESIS
`define MFF_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mff assertion failed");
`define MFF_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mff assertion failed");
`else
`define MFF_ASSERT_IMP(name, clk, rst, pre, post)
`define MFF_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// File: sv/mff_pkg.sv
// types, codes and constants shared by the melt fraction block
// no dependencies
`default_nettype none
package mff_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE = 17'd65536;
  localparam int DIV_NW = 72;
  localparam int DIV_DW = 40;

  localparam logic [1:0] FN_CLEAR   = 2'd0;
  localparam logic [1:0] FN_APP_SOL = 2'd1;
  localparam logic [1:0] FN_APP_LIQ = 2'd2;
  localparam logic [1:0] FN_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_SOL_RAD = 1'b0;
  localparam logic REG_LIQ_RAD = 1'b1;

  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_EXEC       = 5'd2;
  localparam logic [4:0] OP_SRCH_INIT  = 5'd3;
  localparam logic [4:0] OP_TAKE_ONE   = 5'd4;
  localparam logic [4:0] OP_STEP       = 5'd5;
  localparam logic [4:0] OP_LATCH_HI   = 5'd6;
  localparam logic [4:0] OP_LATCH_LO   = 5'd7;
  localparam logic [4:0] OP_TAKE_T0    = 5'd8;
  localparam logic [4:0] OP_MUL_LO     = 5'd9;
  localparam logic [4:0] OP_MUL_HI     = 5'd10;
  localparam logic [4:0] OP_DIV_INT    = 5'd11;
  localparam logic [4:0] OP_INT_FIN    = 5'd12;
  localparam logic [4:0] OP_NEXT_CURVE = 5'd13;
  localparam logic [4:0] OP_MUL_DEP    = 5'd14;
  localparam logic [4:0] OP_ADD_DEP    = 5'd15;
  localparam logic [4:0] OP_W_C        = 5'd16;
  localparam logic [4:0] OP_W_MC       = 5'd17;
  localparam logic [4:0] OP_W_H        = 5'd18;
  localparam logic [4:0] OP_W_MH       = 5'd19;
  localparam logic [4:0] OP_W_D        = 5'd20;
  localparam logic [4:0] OP_TEMPS      = 5'd21;
  localparam logic [4:0] OP_FR_SEL     = 5'd22;
  localparam logic [4:0] OP_MUL_FR     = 5'd23;
  localparam logic [4:0] OP_DIV_FR     = 5'd24;
  localparam logic [4:0] OP_FR_FIN     = 5'd25;
  localparam logic [4:0] OP_PUSH       = 5'd26;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] temperature;
    logic [39:0] pressure;
    logic [23:0] radius;
    logic [15:0] water_fraction;
    logic [16:0] depletion;
  } item_t;

  typedef struct packed {
    logic [16:0]        melt_frac;
    logic signed [31:0] solidus_temp;
    logic signed [31:0] liquidus_temp;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic go_query;
    logic n_le1;
    logic hit;
    logic span_zero;
    logic curve;
    logic div_busy;
    logic frac_mid;
    logic can_push;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: sv/mff_div.sv
// restoring divider, one quotient bit per cycle
// depends on mff_pkg
`default_nettype none
module mff_div import mff_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] dividend,
  input  wire logic [DIV_DW-1:0] divisor,
  output logic                   busy,
  output logic [DIV_NW-1:0]      quotient
);

  localparam int CNTW = $clog2(DIV_NW);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_NW-1:0] nq;
  logic [CNTW-1:0]   cnt;
  logic [DIV_DW:0]   r2;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign r2       = {rem, nq[DIV_NW-1]};
  assign diff     = r2 - {1'b0, dreg};
  assign ge       = r2 >= {1'b0, dreg};
  assign quotient = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNTW'(1);
      if (cnt == CNTW'(DIV_NW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      nq   <= dividend;
      dreg <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DW-1:0] : r2[DIV_DW-1:0];
      nq  <= {nq[DIV_NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: sv/mff_dp.sv
// datapath: curve tables, search index, shared multiplier and divider, result register
// depends on mff_pkg, mff_div and the assertion macro header
`default_nettype none
`include "melt_fraction_from_curves_defines.svh"
module mff_dp import mff_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire logic    cfg_data,
  input  wire item_t   item,
  input  wire dp_cmd_t cmd,
  output dp_stat_t     stat,
  output result_t      result,
  output logic         result_valid,
  input  wire logic    result_stall
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic signed [34:0] K_C2 = 35'sd1946419200;
  localparam logic signed [35:0] K_C1 = 36'sd264765440;
  localparam logic [33:0] K_C3 = 34'd4987289600;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  item_t in_q;
  logic sol_rad, liq_rad;
  logic [CW-1:0] sol_cnt, liq_cnt;
  logic [71:0] sol_mem [MAX_POINTS];
  logic [71:0] liq_mem [MAX_POINTS];
  logic [71:0] sol_q, liq_q;
  logic sol_we, liq_we;
  logic [AW-1:0] idx;
  logic curve;

  logic [31:0] t0, t1;
  logic [39:0] a1;
  logic [31:0] mag_a;
  logic [39:0] mag_b, mag_s;
  logic neg, span_zero;
  logic [53:0] prod, acc;
  logic signed [33:0] s0, l0;
  logic dsign, csign, hsign;
  logic signed [34:0] c;
  logic signed [35:0] h, delta;
  logic signed [31:0] ts, tl;
  logic [16:0] frac;
  logic [1:0] st_code;
  logic [33:0] tdiff_r;
  logic [32:0] dspan_r;

  logic [16:0] dep_s;
  logic [CW-1:0] n;
  logic is_rad;
  logic [39:0] x;
  logic [71:0] rd;
  logic [31:0] rd_t;
  logic [39:0] rd_a;
  logic sol_full, liq_full;
  logic [33:0] mul_a;
  logic [19:0] mul_b;
  logic signed [34:0] diff_ls, neg_ls;
  logic [33:0] dep_mag;
  logic signed [34:0] c_neg;
  logic [33:0] c_mag;
  logic signed [35:0] h_neg;
  logic [33:0] h_mag;
  logic signed [40:0] span, dx;
  logic signed [32:0] dt;
  logic signed [40:0] span_neg, dx_neg;
  logic signed [32:0] dt_neg;
  logic [40:0] qs;
  logic signed [41:0] iv;
  logic signed [31:0] tc;
  logic signed [33:0] t34;
  logic f_le, f_gt;
  logic signed [33:0] tdiff;
  logic signed [32:0] dspan;
  logic take_en;
  logic signed [33:0] take_val;
  logic div_start, div_busy;
  logic [DIV_NW-1:0] div_n, div_quo;
  logic [DIV_DW-1:0] div_d;
  logic can_push, push_fire;

  assign dep_s = (in_q.depletion > FRAC_ONE) ? FRAC_ONE : in_q.depletion;
  assign n = curve ? liq_cnt : sol_cnt;
  assign is_rad = curve ? liq_rad : sol_rad;
  assign x = is_rad ? {16'd0, in_q.radius} : in_q.pressure;
  assign rd = curve ? liq_q : sol_q;
  assign rd_t = rd[71:40];
  assign rd_a = rd[39:0];
  assign sol_full = sol_cnt >= CW'(MAX_POINTS);
  assign liq_full = liq_cnt >= CW'(MAX_POINTS);
  assign sol_we = (cmd.op == OP_EXEC) && (in_q.func == FN_APP_SOL) && !sol_full;
  assign liq_we = (cmd.op == OP_EXEC) && (in_q.func == FN_APP_LIQ) && !liq_full;

  assign diff_ls = 35'(l0) - 35'(s0);
  assign neg_ls  = -diff_ls;
  assign dep_mag = diff_ls[34] ? neg_ls[33:0] : diff_ls[33:0];
  assign c_neg   = -c;
  assign c_mag   = c[34] ? c_neg[33:0] : c[33:0];
  assign h_neg   = -h;
  assign h_mag   = h[35] ? h_neg[33:0] : h[33:0];

  assign span     = $signed({1'b0, a1}) - $signed({1'b0, rd_a});
  assign dx       = $signed({1'b0, x}) - $signed({1'b0, rd_a});
  assign dt       = $signed({1'b0, t1}) - $signed({1'b0, rd_t});
  assign span_neg = -span;
  assign dx_neg   = -dx;
  assign dt_neg   = -dt;

  assign qs = (|div_quo[71:40]) ? {1'b1, 40'd0} : {1'b0, div_quo[39:0]};
  assign iv = neg ? $signed({10'd0, t0}) - $signed({1'b0, qs})
                  : $signed({10'd0, t0}) + $signed({1'b0, qs});

  assign tc    = (ts > tl) ? tl : ts;
  assign t34   = $signed({2'b00, in_q.temperature});
  assign f_le  = t34 <= 34'(tc);
  assign f_gt  = t34 > 34'(tl);
  assign tdiff = t34 - 34'(tc);
  assign dspan = 33'(tl) - 33'(tc);

  assign can_push  = !result_valid || !result_stall;
  assign push_fire = (cmd.op == OP_PUSH) && can_push;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_LO: begin
        mul_a = {2'b00, mag_a};
        mul_b = mag_b[19:0];
      end
      OP_MUL_HI: begin
        mul_a = {2'b00, mag_a};
        mul_b = mag_b[39:20];
      end
      OP_MUL_DEP: begin
        mul_a = dep_mag;
        mul_b = {3'b000, dep_s};
      end
      OP_ADD_DEP: begin
        mul_a = K_C3;
        mul_b = {4'h0, in_q.water_fraction};
      end
      OP_W_MC: begin
        mul_a = c_mag;
        mul_b = {4'h0, in_q.water_fraction};
      end
      OP_W_MH: begin
        mul_a = h_mag;
        mul_b = {4'h0, in_q.water_fraction};
      end
      OP_MUL_FR: begin
        mul_a = tdiff_r;
        mul_b = {3'b000, FRAC_ONE - dep_s};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    take_en  = 1'b0;
    take_val = '0;
    unique case (cmd.op)
      OP_TAKE_ONE: begin
        take_en  = 1'b1;
        take_val = $signed({2'b00, rd_t});
      end
      OP_TAKE_T0: begin
        take_en  = 1'b1;
        take_val = $signed({2'b00, t0});
      end
      OP_INT_FIN: begin
        take_en  = 1'b1;
        take_val = 34'(sat32(iv));
      end
      default: begin
        take_en  = 1'b0;
        take_val = '0;
      end
    endcase
  end

  assign div_start = (cmd.op == OP_DIV_INT) || (cmd.op == OP_DIV_FR);
  assign div_n = (cmd.op == OP_DIV_INT) ? (DIV_NW'(acc) + (DIV_NW'(prod) << 20))
                                        : DIV_NW'(prod);
  assign div_d = (cmd.op == OP_DIV_INT) ? mag_s : DIV_DW'(dspan_r);

  mff_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // tables
  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[sol_cnt[AW-1:0]] <= {in_q.temperature, in_q.pressure};
    end
    if (liq_we) begin
      liq_mem[liq_cnt[AW-1:0]] <= {in_q.temperature, in_q.pressure};
    end
    sol_q <= sol_mem[idx];
    liq_q <= liq_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sol_rad      <= 1'b0;
      liq_rad      <= 1'b0;
      sol_cnt      <= '0;
      liq_cnt      <= '0;
      curve        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOL_RAD: sol_rad <= cfg_data;
          REG_LIQ_RAD: liq_rad <= cfg_data;
          default: ;
        endcase
      end
      if ((cmd.op == OP_EXEC) && (in_q.func == FN_CLEAR)) begin
        sol_cnt <= '0;
        liq_cnt <= '0;
      end
      if (sol_we) begin
        sol_cnt <= sol_cnt + CW'(1);
      end
      if (liq_we) begin
        liq_cnt <= liq_cnt + CW'(1);
      end
      if (cmd.op == OP_LOAD) begin
        curve <= 1'b0;
      end else if (cmd.op == OP_NEXT_CURVE) begin
        curve <= ~curve;
      end
      if (push_fire) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_en) begin
      if (curve) begin
        l0 <= take_val;
      end else begin
        s0 <= take_val;
      end
    end
    prod <= 54'(mul_a) * 54'(mul_b);
    if (push_fire) begin
      result <= '{melt_frac: frac, solidus_temp: ts, liquidus_temp: tl,
                  status: st_code};
    end
    unique case (cmd.op)
      OP_LOAD: begin
        in_q <= item;
      end
      OP_EXEC: begin
        frac <= '0;
        ts   <= '0;
        tl   <= '0;
        unique case (in_q.func)
          FN_CLEAR:   st_code <= ST_OK;
          FN_APP_SOL: st_code <= sol_full ? ST_FULL : ST_OK;
          FN_APP_LIQ: st_code <= liq_full ? ST_FULL : ST_OK;
          FN_QUERY:   st_code <= (sol_cnt == '0 || liq_cnt == '0) ? ST_EMPTY : ST_OK;
          default:    st_code <= ST_OK;
        endcase
      end
      OP_SRCH_INIT: begin
        idx <= (n <= CW'(1)) ? AW'(0) : AW'(1);
      end
      OP_STEP: begin
        idx <= idx + AW'(1);
      end
      OP_LATCH_HI: begin
        t1  <= rd_t;
        a1  <= rd_a;
        idx <= idx - AW'(1);
      end
      OP_LATCH_LO: begin
        t0        <= rd_t;
        span_zero <= (a1 == rd_a);
        mag_s     <= span[40] ? span_neg[39:0] : span[39:0];
        mag_b     <= dx[40] ? dx_neg[39:0] : dx[39:0];
        mag_a     <= dt[32] ? dt_neg[31:0] : dt[31:0];
        neg       <= dt[32] ^ dx[40] ^ span[40];
      end
      OP_MUL_HI: begin
        acc <= prod;
      end
      OP_MUL_DEP: begin
        dsign <= diff_ls[34];
      end
      OP_ADD_DEP: begin
        s0 <= dsign ? s0 - $signed({1'b0, prod[48:16]}) : s0 + $signed({1'b0, prod[48:16]});
      end
      OP_W_C: begin
        c <= K_C2 - $signed({2'b00, prod[48:16]});
      end
      OP_W_MC: begin
        csign <= c[34];
      end
      OP_W_H: begin
        h <= csign ? K_C1 + $signed({2'b00, prod[49:16]})
                   : K_C1 - $signed({2'b00, prod[49:16]});
      end
      OP_W_MH: begin
        hsign <= h[35];
      end
      OP_W_D: begin
        delta <= hsign ? -$signed({2'b00, prod[49:16]}) : $signed({2'b00, prod[49:16]});
      end
      OP_TEMPS: begin
        ts <= sat32(42'(s0) - 42'(delta));
        tl <= sat32(42'(l0) - 42'(delta));
      end
      OP_FR_SEL: begin
        frac    <= f_le ? 17'd0 : (f_gt ? FRAC_ONE : 17'd0);
        tdiff_r <= tdiff;
        dspan_r <= dspan;
        st_code <= ST_OK;
      end
      OP_FR_FIN: begin
        frac <= div_quo[16:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.go_query  = (in_q.func == FN_QUERY) && (sol_cnt != '0) && (liq_cnt != '0);
    stat.n_le1     = n <= CW'(1);
    stat.hit       = (is_rad ? (x > rd_a) : (x < rd_a)) || (CW'(idx) == n - CW'(1));
    stat.span_zero = span_zero;
    stat.curve     = curve;
    stat.div_busy  = div_busy;
    stat.frac_mid  = !f_le && !f_gt;
    stat.can_push  = can_push;
  end

  `MFF_ASSERT_IMP(a_div_free, clk, rst, div_start, !div_busy)
  `MFF_ASSERT_IMP(a_sol_room, clk, rst, sol_we, sol_cnt < CW'(MAX_POINTS))
  `MFF_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, sol_cnt <= CW'(MAX_POINTS) && liq_cnt <= CW'(MAX_POINTS))
  `MFF_ASSERT_NEXT(a_push_shows, clk, rst, push_fire, result_valid)

endmodule
`default_nettype wire

// File: sv/mff_ctrl.sv
// sequencing state machine: segment search, interpolation and melt fraction steps
// depends on mff_pkg; drives mff_dp by command
`default_nettype none
module mff_ctrl import mff_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECODE = 5'd1;
  localparam logic [4:0] S_SINIT  = 5'd2;
  localparam logic [4:0] S_RDWAIT = 5'd3;
  localparam logic [4:0] S_CMP    = 5'd4;
  localparam logic [4:0] S_LOWAIT = 5'd5;
  localparam logic [4:0] S_LO     = 5'd6;
  localparam logic [4:0] S_CHK    = 5'd7;
  localparam logic [4:0] S_MHI    = 5'd8;
  localparam logic [4:0] S_DIVI   = 5'd9;
  localparam logic [4:0] S_WAITI  = 5'd10;
  localparam logic [4:0] S_NEXT   = 5'd11;
  localparam logic [4:0] S_DEP1   = 5'd12;
  localparam logic [4:0] S_DEP2   = 5'd13;
  localparam logic [4:0] S_WC     = 5'd14;
  localparam logic [4:0] S_WMC    = 5'd15;
  localparam logic [4:0] S_WH     = 5'd16;
  localparam logic [4:0] S_WMH    = 5'd17;
  localparam logic [4:0] S_WD     = 5'd18;
  localparam logic [4:0] S_TEMPS  = 5'd19;
  localparam logic [4:0] S_FSEL   = 5'd20;
  localparam logic [4:0] S_MFR    = 5'd21;
  localparam logic [4:0] S_DIVF   = 5'd22;
  localparam logic [4:0] S_WAITF  = 5'd23;
  localparam logic [4:0] S_PUSH   = 5'd24;

  logic [4:0] state, state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op     = OP_EXEC;
        state_next = stat.go_query ? S_SINIT : S_PUSH;
      end
      S_SINIT: begin
        cmd.op     = OP_SRCH_INIT;
        state_next = S_RDWAIT;
      end
      S_RDWAIT: state_next = S_CMP;
      S_CMP: begin
        if (stat.n_le1) begin
          cmd.op     = OP_TAKE_ONE;
          state_next = S_NEXT;
        end else if (stat.hit) begin
          cmd.op     = OP_LATCH_HI;
          state_next = S_LOWAIT;
        end else begin
          cmd.op     = OP_STEP;
          state_next = S_RDWAIT;
        end
      end
      S_LOWAIT: state_next = S_LO;
      S_LO: begin
        cmd.op     = OP_LATCH_LO;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.span_zero) begin
          cmd.op     = OP_TAKE_T0;
          state_next = S_NEXT;
        end else begin
          cmd.op     = OP_MUL_LO;
          state_next = S_MHI;
        end
      end
      S_MHI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.op     = OP_DIV_INT;
        state_next = S_WAITI;
      end
      S_WAITI: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_INT_FIN;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.op     = OP_NEXT_CURVE;
        state_next = stat.curve ? S_DEP1 : S_SINIT;
      end
      S_DEP1: begin
        cmd.op     = OP_MUL_DEP;
        state_next = S_DEP2;
      end
      S_DEP2: begin
        cmd.op     = OP_ADD_DEP;
        state_next = S_WC;
      end
      S_WC: begin
        cmd.op     = OP_W_C;
        state_next = S_WMC;
      end
      S_WMC: begin
        cmd.op     = OP_W_MC;
        state_next = S_WH;
      end
      S_WH: begin
        cmd.op     = OP_W_H;
        state_next = S_WMH;
      end
      S_WMH: begin
        cmd.op     = OP_W_MH;
        state_next = S_WD;
      end
      S_WD: begin
        cmd.op     = OP_W_D;
        state_next = S_TEMPS;
      end
      S_TEMPS: begin
        cmd.op     = OP_TEMPS;
        state_next = S_FSEL;
      end
      S_FSEL: begin
        cmd.op     = OP_FR_SEL;
        state_next = stat.frac_mid ? S_MFR : S_PUSH;
      end
      S_MFR: begin
        cmd.op     = OP_MUL_FR;
        state_next = S_DIVF;
      end
      S_DIVF: begin
        cmd.op     = OP_DIV_FR;
        state_next = S_WAITF;
      end
      S_WAITF: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_FR_FIN;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.op = OP_PUSH;
        if (stat.can_push) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/melt_fraction_from_curves.sv
// melt fraction from solidus and liquidus curves: top level
// instantiates mff_ctrl and mff_dp; depends on mff_pkg
//
// item channel (item_valid/item_stall/item) carries one command beat: clear both
// curves, append a solidus or liquidus point, or query at a temperature and depth.
// every item gives exactly one beat on the result channel (result_valid/result_stall).
// cfg_we writes the axis-is-radius bit selected by cfg_index; the user must write it only
// while idle; the block does not enforce this. one item is worked on at a time; item_stall
// is high from the cycle after acceptance until the result is placed in the output register.
// clear and append: the item is registered and executed, then the result register is loaded.
// query: the table is read for each searched point in each curve, and the serial
// divider is used three times (one per curve, one for the fraction); a one-point curve or a
// zero-width segment skips its divider pass, and a fraction of 0 or 1.0 skips the last.
// a stalled result holds in the output register while the next item is taken;
// a finished item waits only if that register is still full.
// reset empties both curves and clears the axis bits; table contents are kept.
`default_nettype none
module melt_fraction_from_curves import mff_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire logic  cfg_data,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mff_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  mff_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
`default_nettype wire

// File: sim/tb_melt_fraction_from_curves.sv
// self-checking testbench for melt_fraction_from_curves
// depends on mff_pkg and the melt_fraction_from_curves rtl; predicts each result beat itself
// curves are built in order, queried under all axis settings and idling phases
`timescale 1ns / 1ps
module tb_melt_fraction_from_curves;
  import mff_pkg::*;

  localparam int NPTS = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 375;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_SOL_RAD;
  logic cfg_data = 1'b0;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  melt_fraction_from_curves dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  item_t   item_q[$];
  result_t melt_expect_q[$];
  logic [31:0] sol_temp[NPTS];
  logic [39:0] sol_ax[NPTS];
  logic [31:0] liq_temp[NPTS];
  logic [39:0] liq_ax[NPTS];
  int sol_n = 0;
  int liq_n = 0;
  bit sol_rad = 1'b0;
  bit liq_rad = 1'b0;
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int n_items = 0;
  int n_interp = 0;
  int n_partial = 0;
  int idle_cycles = 0;
  longint ax_lo, ax_hi;

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint frac_mul(longint v, longint m);
    longint r;
    r = (mag(v) * m) >>> FRAC_BITS;
    return v < 0 ? -r : r;
  endfunction

  function automatic longint curve_temp(bit liq, bit is_rad, logic [39:0] x);
    logic [31:0] tt[NPTS];
    logic [39:0] ax[NPTS];
    int n, i;
    longint t0, dt, dx, span;
    logic [127:0] prod, quo;
    bit neg;
    if (liq) begin
      tt = liq_temp; ax = liq_ax; n = liq_n;
    end else begin
      tt = sol_temp; ax = sol_ax; n = sol_n;
    end
    if (n <= 1) return longint'({32'b0, tt[0]});
    for (i = 1; i < n - 1; i++) begin
      if (is_rad ? (x > ax[i]) : (x < ax[i])) break;
    end
    t0 = longint'({32'b0, tt[i-1]});
    span = longint'({24'b0, ax[i]}) - longint'({24'b0, ax[i-1]});
    if (span == 0) return t0;
    dt = longint'({32'b0, tt[i]}) - t0;
    dx = longint'({24'b0, x}) - longint'({24'b0, ax[i-1]});
    neg = ((dt < 0) != (dx < 0)) != (span < 0);
    prod = {64'b0, mag(dt)} * {64'b0, mag(dx)};
    quo = prod / {64'b0, mag(span)};
    if (quo >= (128'd1 << 40)) quo = 128'd1 << 40;
    return sat32(neg ? t0 - longint'(quo[63:0]) : t0 + longint'(quo[63:0]));
  endfunction

  task automatic add_item(input item_t it);
    item_q.insert(item_q.size(), it);
  endtask

  task automatic predict_melt(input item_t it);
    result_t r;
    longint s0, l0, c, h, dl, ts, tl, tc, t, dep, frac;
    logic [39:0] xs, xl;
    r = '0;
    dep = (it.depletion > FRAC_ONE) ? 65536 : longint'(it.depletion);
    case (it.func)
      FN_CLEAR: begin
        sol_n = 0;
        liq_n = 0;
      end
      FN_APP_SOL: begin
        if (sol_n >= NPTS) r.status = ST_FULL;
        else begin
          sol_temp[sol_n] = it.temperature;
          sol_ax[sol_n] = it.pressure;
          sol_n++;
        end
      end
      FN_APP_LIQ: begin
        if (liq_n >= NPTS) r.status = ST_FULL;
        else begin
          liq_temp[liq_n] = it.temperature;
          liq_ax[liq_n] = it.pressure;
          liq_n++;
        end
      end
      default: begin
        if (sol_n == 0 || liq_n == 0) r.status = ST_EMPTY;
        else begin
          xs = sol_rad ? {16'b0, it.radius} : it.pressure;
          xl = liq_rad ? {16'b0, it.radius} : it.pressure;
          s0 = curve_temp(1'b0, sol_rad, xs);
          l0 = curve_temp(1'b1, liq_rad, xl);
          s0 += frac_mul(l0 - s0, dep);
          c = 64'sd29700 * 65536 - frac_mul(64'sd76100 * 65536, it.water_fraction);
          h = 64'sd4040 * 65536 - frac_mul(c, it.water_fraction);
          dl = frac_mul(h, it.water_fraction);
          ts = sat32(s0 - dl);
          tl = sat32(l0 - dl);
          tc = ts > tl ? tl : ts;
          t = longint'({32'b0, it.temperature});
          if (t <= tc) frac = 0;
          else if (t > tl) frac = 65536;
          else begin
            frac = ((t - tc) * (65536 - dep)) / (tl - tc);
            n_partial++;
          end
          r.melt_frac = frac[16:0];
          r.solidus_temp = ts[31:0];
          r.liquidus_temp = tl[31:0];
          n_interp++;
        end
      end
    endcase
    melt_expect_q.insert(melt_expect_q.size(), r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_melt(item);
        n_items++;
      end
      if (!item_valid || !item_stall) begin
        if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          item_valid <= 1'b1;
          item <= item_q.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall);
      if (result_valid && !result_stall) begin
        if (melt_expect_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, result);
          errors++;
        end else begin
          e = melt_expect_q.pop_front();
          if (result.melt_frac !== e.melt_frac) begin
            $display("%0t: melt_frac exp %0d got %0d", $time, e.melt_frac,
                     result.melt_frac);
            errors++;
          end
          if (result.solidus_temp !== e.solidus_temp) begin
            $display("%0t: solidus_temp exp %0d got %0d", $time, e.solidus_temp,
                     result.solidus_temp);
            errors++;
          end
          if (result.liquidus_temp !== e.liquidus_temp) begin
            $display("%0t: liquidus_temp exp %0d got %0d", $time, e.liquidus_temp,
                     result.liquidus_temp);
            errors++;
          end
          if (result.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, result.status);
            errors++;
          end
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_melt_fraction_from_curves: FAIL");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t mk_item(logic [1:0] f, logic [31:0] t, logic [39:0] p);
    item_t it;
    it = '0;
    it.func = f;
    it.temperature = t;
    it.pressure = p;
    return it;
  endfunction

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(255)), 32'($urandom())};
  endfunction

  task automatic push_curve(bit liq, bit is_rad, int n);
    longint a, t;
    item_t it;
    a = is_rad ? longint'($urandom_range(16777215, 4000000)) : longint'($urandom_range(1 << 30));
    t = longint'($urandom_range(2500, 900)) <<< 16;
    if (liq) t += longint'($urandom_range(400, 100)) <<< 16;
    ax_lo = a;
    ax_hi = a;
    for (int k = 0; k < n; k++) begin
      it = mk_item(liq ? FN_APP_LIQ : FN_APP_SOL, t[31:0], a[39:0]);
      add_item(it);
      if (a < ax_lo) ax_lo = a;
      if (a > ax_hi) ax_hi = a;
      t += longint'($urandom_range(200 << 16)) - (64 << 16);
      if (t < 0) t = 0;
      if ($urandom_range(7) != 0) begin
        if (is_rad) a -= longint'($urandom_range(1 << 20));
        else a += longint'($urandom_range(1 << 28));
      end
      if (a < 0) a = 0;
    end
  endtask

  task automatic push_query();
    item_t it;
    longint d, x;
    it = '0;
    it.func = FN_QUERY;
    d = (ax_hi - ax_lo) / 4 + 1;
    x = ax_lo - d + longint'($urandom_range(32'(ax_hi - ax_lo + 2 * d)));
    if (x < 0) x = 0;
    if ($urandom_range(9) == 0) begin
      it.pressure = rand40();
      it.radius = 24'($urandom());
    end else begin
      it.pressure = x[39:0];
      it.radius = (x > 16777215) ? 24'hffffff : x[23:0];
    end
    it.temperature = ($urandom_range(3) == 0) ? $urandom() :
                     32'(($urandom_range(3000, 800) << 16) | $urandom_range(65535));
    it.water_fraction = $urandom_range(1) ? 16'($urandom_range(2000)) : 16'($urandom());
    case ($urandom_range(4))
      0, 1: it.depletion = '0;
      2, 3: it.depletion = 17'($urandom_range(65536));
      default: it.depletion = 17'($urandom_range(131071));
    endcase
    add_item(it);
  endtask

  task automatic push_directed();
    item_t it;
    add_item(mk_item(FN_CLEAR, '0, '0));
    add_item(mk_item(FN_QUERY, 32'd1000 << 16, '0));
    add_item(mk_item(FN_APP_SOL, 32'd1200 << 16, 40'd1000));
    add_item(mk_item(FN_QUERY, 32'd1300 << 16, '0));
    add_item(mk_item(FN_APP_LIQ, 32'd1600 << 16, 40'd0));
    // single point on each curve
    add_item(mk_item(FN_QUERY, 32'd1400 << 16, 40'd5));
    add_item(mk_item(FN_QUERY, 32'd1100 << 16, 40'd5));
    add_item(mk_item(FN_QUERY, 32'd1700 << 16, 40'd5));
    // zero-width solidus segment
    add_item(mk_item(FN_APP_SOL, 32'd1500 << 16, 40'd1000));
    add_item(mk_item(FN_APP_LIQ, 32'hffffffff, 40'hffffffffff));
    it = mk_item(FN_QUERY, 32'hffffffff, 40'hffffffffff);
    it.radius = 24'hffffff;
    it.water_fraction = 16'hffff;
    it.depletion = 17'h1ffff;
    add_item(it);
    it = mk_item(FN_QUERY, 32'd1400 << 16, 40'd1 << 39);
    it.depletion = FRAC_ONE;
    add_item(it);
    it = mk_item(FN_QUERY, 32'd1450 << 16, 40'd0);
    it.depletion = 17'd32768;
    it.water_fraction = 16'd1000;
    add_item(it);
    add_item(mk_item(FN_QUERY, '0, 40'd3000));
    // steep extrapolation far off the table
    add_item(mk_item(FN_APP_SOL, 32'hffffffff, 40'd1001));
    add_item(mk_item(FN_QUERY, 32'd1 << 16, 40'hffffffffff));
    add_item(mk_item(FN_CLEAR, 32'hffffffff, 40'hffffffffff));
    add_item(mk_item(FN_QUERY, 32'd1 << 16, 40'd7));
  endtask

  task automatic push_phase(int budget);
    int ns, nl, nq, start;
    item_t it;
    start = item_q.size();
    // table full on both curves
    add_item(mk_item(FN_CLEAR, '0, '0));
    push_curve(1'b0, sol_rad, NPTS + 2);
    push_curve(1'b1, liq_rad, NPTS + 1);
    repeat (3) push_query();
    while (item_q.size() - start < budget) begin
      if ($urandom_range(99) < 15) begin
        it.func = 2'($urandom());
        it.temperature = $urandom();
        it.pressure = rand40();
        it.radius = 24'($urandom());
        it.water_fraction = 16'($urandom());
        it.depletion = 17'($urandom());
        add_item(it);
      end else begin
        ns = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : $urandom_range(6, 1);
        nl = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : $urandom_range(6, 1);
        add_item(mk_item(FN_CLEAR, '0, '0));
        if ($urandom_range(1)) begin
          push_curve(1'b1, liq_rad, nl);
          push_curve(1'b0, sol_rad, ns);
        end else begin
          push_curve(1'b0, sol_rad, ns);
          push_curve(1'b1, liq_rad, nl);
        end
        nq = $urandom_range(10, 3);
        repeat (nq) push_query();
      end
    end
  endtask

  task automatic drain();
    while (item_q.size() > 0 || item_valid) @(posedge clk);
    while (melt_expect_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_axes(bit s, bit l);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SOL_RAD;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_LIQ_RAD;
    cfg_data <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    sol_rad = s;
    liq_rad = l;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    push_directed();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_axes(ph[0], ph[1]);
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 62; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 62; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      push_phase(PHASE_ITEMS / 2);
      // sender holds off until every result is back
      drain();
      push_phase(PHASE_ITEMS / 2);
      drain();
    end
    write_axes(1'b0, 1'b0);
    repeat (600) @(posedge clk);
    $display("%0d items, %0d interpolated queries (%0d partial melt), all axis settings",
             n_items, n_interp, n_partial);
    if (errors == 0) $display("tb_melt_fraction_from_curves: PASS");
    else $display("tb_melt_fraction_from_curves: FAIL");
    $finish;
  end

endmodule
